FILE: rtl/zbm_pkg.sv
// shared constants and controller/datapath interface types of the zero-byte-mask decoder
package zbm_pkg;

    // default block length in output bytes (range 1 to 8)
    localparam int ZBM_BLOCK_BYTES = 8;

    // header marker and type bytes
    localparam logic [7:0] HDR_MARK0 = 8'h6D;
    localparam logic [7:0] HDR_MARK1 = 8'h73;
    localparam logic [7:0] HDR_MARK2 = 8'h6B;
    localparam logic [7:0] HDR_TYPE  = 8'h04;

    // header byte indexes
    localparam logic [2:0] HDR_IDX_MARK0 = 3'd0;
    localparam logic [2:0] HDR_IDX_MARK1 = 3'd1;
    localparam logic [2:0] HDR_IDX_MARK2 = 3'd2;
    localparam logic [2:0] HDR_IDX_TYPE  = 3'd3;
    localparam logic [2:0] HDR_IDX_SIZE0 = 3'd4;
    localparam logic [2:0] HDR_IDX_SIZE1 = 3'd5;
    localparam logic [2:0] HDR_IDX_SIZE2 = 3'd6;
    localparam logic [2:0] HDR_IDX_SIZE3 = 3'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the input byte
        logic step;   // run one decode step
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic slot_free;  // output register can take a result this cycle
        logic done;       // the current step finishes the item
    } t_stat;

endpackage

FILE: rtl/zbm_ctrl.sv
// controller state machine: input handshake and step sequencing
module zbm_ctrl
    import zbm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic {
        S_IDLE,
        S_PROC
    } t_state;

    t_state r_state;
    t_state n_state;

    // commands
    assign o_cmd.load = i_valid && (r_state == S_IDLE);
    assign o_cmd.step = (r_state == S_PROC) && i_stat.slot_free;
    assign o_stall    = (r_state == S_PROC);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (o_cmd.step && i_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/zbm_dpath.sv
// datapath: header check, block mask walk, size count and output register
module zbm_dpath
    import zbm_pkg::*;
#(
    parameter int BLOCK_BYTES = ZBM_BLOCK_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_in_byte,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_stream,
    output logic       o_status
);

    localparam logic [31:0] BLK_LEN32 = 32'(BLOCK_BYTES);
    localparam logic [3:0]  BLK_LEN   = 4'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_MASK,
        PH_DATA,
        PH_ERROR
    } t_phase;

    // decode state
    t_phase      r_phase,  n_phase;
    logic        r_adv,    n_adv;
    logic [2:0]  r_hc,     n_hc;
    logic [31:0] r_size,   n_size;
    logic [7:0]  r_mask,   n_mask;
    logic [3:0]  r_bitpos, n_bitpos;
    logic [3:0]  r_blen,   n_blen;
    logic [7:0]  r_byte,   n_byte;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_has;
    logic        r_out_last;
    logic        r_out_end;
    logic        r_out_status;

    // step results
    logic        emit;
    logic        done;
    logic [7:0]  res_byte;
    logic        res_has;
    logic        res_last;
    logic        res_end;
    logic        res_status;

    // helpers
    logic [3:0]  bp_inc;
    logic [31:0] size_dec;
    logic        more_zero;
    logic [31:0] size_hdr;
    logic        hdr_bad;
    logic [3:0]  blen_new;

    assign bp_inc    = r_bitpos + 4'd1;
    assign size_dec  = r_size - 32'd1;
    // another zero follows in this block after the byte being emitted
    assign more_zero = (bp_inc < r_blen) && !r_mask[bp_inc[2:0]];
    assign blen_new  = (r_size >= BLK_LEN32) ? BLK_LEN : r_size[3:0];

    // header byte check and size assembly, little-endian
    always_comb begin
        hdr_bad  = 1'b0;
        size_hdr = r_size;
        case (r_hc)
            HDR_IDX_MARK0: hdr_bad  = (r_byte != HDR_MARK0);
            HDR_IDX_MARK1: hdr_bad  = (r_byte != HDR_MARK1);
            HDR_IDX_MARK2: hdr_bad  = (r_byte != HDR_MARK2);
            HDR_IDX_TYPE:  hdr_bad  = (r_byte != HDR_TYPE);
            HDR_IDX_SIZE0: size_hdr = {24'd0, r_byte};
            HDR_IDX_SIZE1: size_hdr = r_size | {16'd0, r_byte, 8'd0};
            HDR_IDX_SIZE2: size_hdr = r_size | {8'd0, r_byte, 16'd0};
            HDR_IDX_SIZE3: size_hdr = r_size | {r_byte, 24'd0};
            default:       hdr_bad  = 1'b0;
        endcase
    end

    // one decode step
    always_comb begin
        n_phase    = r_phase;
        n_adv      = r_adv;
        n_hc       = r_hc;
        n_size     = r_size;
        n_mask     = r_mask;
        n_bitpos   = r_bitpos;
        n_blen     = r_blen;
        n_byte     = r_byte;
        emit       = 1'b0;
        done       = 1'b0;
        res_byte   = 8'd0;
        res_has    = 1'b0;
        res_last   = 1'b0;
        res_end    = 1'b0;
        res_status = 1'b0;

        if (i_cmd.load) begin
            n_byte = i_in_byte;
        end

        if (i_cmd.step) begin
            if (r_adv) begin
                // walk the block: stop at a set bit or the block end
                if (r_bitpos >= r_blen) begin
                    n_adv = 1'b0;
                    done  = 1'b1;
                    if (r_size == 32'd0) begin
                        n_phase = PH_HEADER;
                        n_hc    = HDR_IDX_MARK0;
                    end else begin
                        n_phase = PH_MASK;
                    end
                end else if (r_mask[r_bitpos[2:0]]) begin
                    n_adv   = 1'b0;
                    n_phase = PH_DATA;
                    done    = 1'b1;
                end else begin
                    emit     = 1'b1;
                    res_has  = 1'b1;
                    res_last = !more_zero;
                    res_end  = !more_zero && (bp_inc >= r_blen) && (size_dec == 32'd0);
                    n_bitpos = bp_inc;
                    n_size   = size_dec;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        done   = 1'b1;
                        n_size = size_hdr;
                        if (hdr_bad) begin
                            emit       = 1'b1;
                            res_last   = 1'b1;
                            res_status = 1'b1;
                            n_phase    = PH_ERROR;
                        end else if (r_hc == HDR_IDX_SIZE3) begin
                            n_hc = HDR_IDX_MARK0;
                            if (size_hdr == 32'd0) begin
                                emit     = 1'b1;
                                res_last = 1'b1;
                                res_end  = 1'b1;
                            end else begin
                                n_phase = PH_MASK;
                            end
                        end else begin
                            n_hc = r_hc + 3'd1;
                        end
                    end
                    PH_MASK: begin
                        n_mask   = r_byte;
                        n_bitpos = 4'd0;
                        n_blen   = blen_new;
                        n_adv    = 1'b1;
                    end
                    PH_DATA: begin
                        emit     = 1'b1;
                        res_byte = r_byte;
                        res_has  = 1'b1;
                        res_last = !more_zero;
                        res_end  = !more_zero && (bp_inc >= r_blen) && (size_dec == 32'd0);
                        n_bitpos = bp_inc;
                        n_size   = size_dec;
                        n_adv    = 1'b1;
                    end
                    default: begin
                        // error phase swallows every byte
                        done = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_stat.slot_free = !r_out_valid || !i_stall;
    assign o_stat.done      = done;

    // decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_adv    <= 1'b0;
            r_hc     <= HDR_IDX_MARK0;
            r_size   <= 32'd0;
            r_mask   <= 8'd0;
            r_bitpos <= 4'd0;
            r_blen   <= 4'd0;
        end else begin
            r_phase  <= n_phase;
            r_adv    <= n_adv;
            r_hc     <= n_hc;
            r_size   <= n_size;
            r_mask   <= n_mask;
            r_bitpos <= n_bitpos;
            r_blen   <= n_blen;
        end
    end

    // input byte holding register
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= res_byte;
            r_out_has    <= res_has;
            r_out_last   <= res_last;
            r_out_end    <= res_end;
            r_out_status <= res_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_has_byte      = r_out_has;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_stream = r_out_end;
    assign o_status        = r_out_status;

    // marker-only results always close the run
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> r_out_last)
        else $error("marker result without last_of_run");

    // end of stream only on the final result of a run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_last)
        else $error("end_of_stream without last_of_run");

    // block position never runs past the block length
    a_bitpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos <= r_blen)
        else $error("bit position beyond block length");

    // an error result locks the decoder in the error phase
    a_error_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && res_status) |=> (r_phase == PH_ERROR))
        else $error("error result without error phase");

endmodule

FILE: rtl/zero_byte_mask_block_decoder.sv
// top level of the zero-byte-mask block decoder
// Decodes a zero-byte-mask stream taken one byte per transfer: an 8-byte header ('m','s','k',
// type 4, 32-bit little-endian size), then per block of up to BLOCK_BYTES output bytes one
// mask byte whose clear bits give zero bytes and whose set bits pass the next literal byte.
// The block handles one input byte at a time and writes at most one result per cycle into
// an output register, so a new byte is taken while the last result still waits. A header
// byte takes its transfer plus one decode step; a mask byte takes its transfer, a load step,
// a walk step for each zero that follows it in the block and a closing step; a literal byte
// takes its transfer, an emit step, a walk step for each zero after it and a closing step.
// Steps wait while the output register is full and stalled. A bad header gives one error result
// and the block then drops all input until reset; a zero size gives one end marker with no byte.
module zero_byte_mask_block_decoder
    import zbm_pkg::*;
#(
    parameter int BLOCK_BYTES = ZBM_BLOCK_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_stream,
    output logic       o_status
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    zbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // decode datapath
    zbm_dpath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_byte       (i_in_byte),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream),
        .o_status        (o_status)
    );

endmodule
